// ===== rtl/gns_pkg.sv =====
`default_nettype none

package gns_pkg;

	// One input word: a normal and its group flags.
	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic               is_center;
		logic               is_self;
		logic               is_last;
	} gns_in_t;

	// One output word: the normalized filtered normal.
	typedef struct packed {
		logic signed [15:0] filtered_x;
		logic signed [15:0] filtered_y;
		logic signed [15:0] filtered_z;
	} gns_out_t;

	// Datapath operations issued by the controller.
	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_CENTER,
		OP_DIFF,
		OP_H,
		OP_P1,
		OP_P2,
		OP_P3,
		OP_SQI_W,
		OP_SQI_L,
		OP_SQS,
		OP_ACS,
		OP_ANG2,
		OP_TMUL,
		OP_RINIT,
		OP_TYM,
		OP_TYR,
		OP_TYC,
		OP_EXP,
		OP_ADD,
		OP_MAG,
		OP_SHR,
		OP_SHL,
		OP_LEN,
		OP_DVI,
		OP_DVS,
		OP_DVO,
		OP_OUT
	} gns_op_t;

	typedef struct packed {
		gns_op_t    op;
		logic [1:0] idx;
		logic [3:0] j;
	} gns_cmd_t;

	typedef struct packed {
		logic too_big;
		logic too_small;
		logic sum_zero;
	} gns_stat_t;

	localparam int SQ_STEPS  = 25;
	localparam int DIV_STEPS = 16;
	localparam int TAYLOR_N  = 8;
	localparam logic [15:0] INV_RESET = 16'd13281;

	// exp(-k) in Q.24 for k = 0..16.
	function automatic logic [24:0] exp_int(input logic [4:0] k);
		logic [24:0] v;
		begin
			unique case (k)
				5'd0:  v = 25'd16777216;
				5'd1:  v = 25'd6171993;
				5'd2:  v = 25'd2270549;
				5'd3:  v = 25'd835288;
				5'd4:  v = 25'd307285;
				5'd5:  v = 25'd113044;
				5'd6:  v = 25'd41587;
				5'd7:  v = 25'd15299;
				5'd8:  v = 25'd5628;
				5'd9:  v = 25'd2070;
				5'd10: v = 25'd762;
				5'd11: v = 25'd280;
				5'd12: v = 25'd103;
				5'd13: v = 25'd38;
				5'd14: v = 25'd14;
				5'd15: v = 25'd5;
				5'd16: v = 25'd2;
				default: v = 25'd0;
			endcase
			return v;
		end
	endfunction

	// Reciprocal of the Taylor divisor in Q.32, rounded down.
	function automatic logic [31:0] recip(input logic [3:0] j);
		logic [31:0] v;
		begin
			unique case (j)
				4'd1: v = 32'hFFFF_FFFF;
				4'd2: v = 32'h8000_0000;
				4'd3: v = 32'h5555_5555;
				4'd4: v = 32'h4000_0000;
				4'd5: v = 32'h3333_3333;
				4'd6: v = 32'h2AAA_AAAA;
				4'd7: v = 32'h2492_4924;
				4'd8: v = 32'h2000_0000;
				default: v = 32'h0;
			endcase
			return v;
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/gns_datapath.sv =====
`default_nettype none

module gns_datapath import gns_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire gns_cmd_t  cmd,
	input  wire gns_in_t   in_data,
	input  wire logic      cfg_we,
	input  wire logic [15:0] cfg_wdata,
	output gns_stat_t      stat,
	output gns_out_t       out_data
);

	localparam logic [49:0] ONE_F  = 50'd16384;
	localparam logic [49:0] TWO_F  = 50'd32768;
	localparam logic [16:0] PI_F   = 17'd51472;
	localparam logic [49:0] SQ_B0  = 50'h1_0000_0000_0000;
	localparam logic [24:0] ONE24  = 25'h100_0000;

	logic [15:0]        inv_q;
	logic signed [15:0] n_q   [3];
	logic signed [15:0] cn_q  [3];
	logic signed [31:0] sum_q [3];
	logic [31:0]        mag_q [3];
	logic [15:0]        res_q [3];
	logic [49:0]        acc_q;
	logic [14:0]        a_q;
	logic               neg_q;
	logic [16:0]        p_q;
	logic [49:0]        sx_q;
	logic [49:0]        sr_q;
	logic [49:0]        sb_q;
	logic [15:0]        ang_q;
	logic [31:0]        sq_q;
	logic [24:0]        t_q;
	logic [24:0]        r_q;
	logic [23:0]        x_q;
	logic [23:0]        q_q;
	logic [16:0]        w_q;
	logic [15:0]        numlo_q;
	logic [24:0]        rem_q;
	logic [15:0]        quo_q;
	gns_out_t           out_q;

	logic signed [16:0] diff;
	logic [15:0]        dmag;
	logic signed [16:0] nsx;
	logic [16:0]        nmag;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [63:0]        prod;
	logic [49:0]        hfull;
	logic [15:0]        h;
	logic               hneg;
	logic [49:0]        sq_try;
	logic [16:0]        acs;
	logic [23:0]        trem;
	logic [23:0]        qfix;
	logic [8:0]         tk;
	logic [4:0]         tk_idx;
	logic [49:0]        esum;
	logic [33:0]        tsum;
	logic signed [33:0] sum_ext;
	logic signed [33:0] term_ext;
	logic signed [33:0] vsum;
	logic [31:0]        vsat;
	logic [38:0]        num;
	logic [25:0]        rem2;
	logic [14:0]        qcap;
	logic [15:0]        qext;

	// Operand magnitudes for the distance and the sum terms.
	always_comb begin
		diff = {cn_q[cmd.idx][15], cn_q[cmd.idx]} - {n_q[cmd.idx][15], n_q[cmd.idx]};
		dmag = diff[16] ? 16'(-diff) : diff[15:0];
		nsx  = {n_q[cmd.idx][15], n_q[cmd.idx]};
		nmag = nsx[16] ? 17'(-nsx) : 17'(nsx);
	end

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		unique case (cmd.op)
			OP_DIFF: begin
				mul_a = 32'(dmag);
				mul_b = 32'(dmag);
			end
			OP_P1: begin
				mul_a = 32'd1227;
				mul_b = 32'(a_q);
			end
			OP_P2, OP_P3: begin
				mul_a = 32'(p_q);
				mul_b = 32'(a_q);
			end
			OP_ACS: begin
				mul_a = 32'(p_q);
				mul_b = sr_q[31:0];
			end
			OP_ANG2: begin
				mul_a = 32'(ang_q);
				mul_b = 32'(ang_q);
			end
			OP_TMUL: begin
				mul_a = sq_q;
				mul_b = 32'(inv_q);
			end
			OP_TYM: begin
				mul_a = 32'(t_q[15:0]);
				mul_b = 32'(r_q);
			end
			OP_TYR: begin
				mul_a = 32'(x_q);
				mul_b = recip(cmd.j);
			end
			OP_TYC: begin
				mul_a = 32'(q_q);
				mul_b = 32'(cmd.j);
			end
			OP_EXP: begin
				mul_a = 32'(exp_int(tk_idx));
				mul_b = 32'(r_q);
			end
			OP_ADD: begin
				mul_a = 32'(w_q);
				mul_b = 32'(nmag);
			end
			OP_LEN: begin
				mul_a = 32'(mag_q[cmd.idx][23:0]);
				mul_b = 32'(mag_q[cmd.idx][23:0]);
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
		prod = 64'(mul_a) * 64'(mul_b);
	end

	// Angle, exponential and accumulation helpers.
	always_comb begin
		hfull  = (acc_q + ONE_F) >> 15;
		h      = (hfull > TWO_F) ? 16'(TWO_F) : hfull[15:0];
		hneg   = (50'(h) > ONE_F);
		sq_try = sr_q + sb_q;
		acs    = 17'((prod[33:0] + 34'd32768) >> 16);
		trem   = x_q - prod[23:0];
		qfix   = (trem >= 24'(cmd.j)) ? (q_q + 24'd1) : q_q;
		tk     = t_q[24:16];
		tk_idx = (tk > 9'd16) ? 5'd16 : tk[4:0];
		esum   = prod[49:0] + 50'h80_0000;
		tsum   = prod[33:0] + 34'd32768;
		sum_ext  = 34'(sum_q[cmd.idx]);
		term_ext = $signed({16'd0, tsum[33:16]});
		vsum     = nsx[16] ? (sum_ext - term_ext) : (sum_ext + term_ext);
		vsat     = (vsum[33:31] == 3'b000 || vsum[33:31] == 3'b111) ? vsum[31:0] :
			(vsum[33] ? 32'h8000_0000 : 32'h7FFF_FFFF);
		num  = {mag_q[cmd.idx][23:0], 15'd0} >> 1;
		num  = num + 39'(sr_q[24:1]);
		rem2 = {rem_q, numlo_q[15]};
		qcap = (quo_q > 16'(ONE_F)) ? 15'(ONE_F) : quo_q[14:0];
		qext = {1'b0, qcap};
	end

	// Status for the normalizing loops and the zero sum.
	always_comb begin
		stat.too_big   = (mag_q[0][31:24] != 8'd0) || (mag_q[1][31:24] != 8'd0) ||
			(mag_q[2][31:24] != 8'd0);
		stat.too_small = (mag_q[0][31:23] == 9'd0) && (mag_q[1][31:23] == 9'd0) &&
			(mag_q[2][31:23] == 9'd0);
		stat.sum_zero  = (sum_q[0] == 32'sd0) && (sum_q[1] == 32'sd0) &&
			(sum_q[2] == 32'sd0);
	end

	// Group state, cleared by reset, and the configuration register, reset to INV_RESET.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= INV_RESET;
			for (int i = 0; i < 3; i++) begin
				cn_q[i]  <= 16'sd0;
				sum_q[i] <= 32'sd0;
			end
		end else begin
			if (cfg_we) begin
				inv_q <= cfg_wdata;
			end
			if (cmd.op == OP_CENTER) begin
				for (int i = 0; i < 3; i++) begin
					cn_q[i]  <= n_q[i];
					sum_q[i] <= 32'(n_q[i]);
				end
			end else if (cmd.op == OP_ADD) begin
				sum_q[cmd.idx] <= vsat;
			end
		end
	end

	// Working registers of the weight and normalization sequences.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				n_q[0] <= in_data.normal_x;
				n_q[1] <= in_data.normal_y;
				n_q[2] <= in_data.normal_z;
			end
			OP_DIFF, OP_LEN: begin
				acc_q <= ((cmd.idx == 2'd0) ? 50'd0 : acc_q) + prod[49:0];
			end
			OP_H: begin
				neg_q <= hneg;
				a_q   <= hneg ? 15'(h - 16'(ONE_F)) : 15'(16'(ONE_F) - h);
			end
			OP_P1: p_q <= 17'd4867 - 17'(prod >> 14);
			OP_P2: p_q <= 17'd13901 - 17'(prod >> 14);
			OP_P3: p_q <= 17'd102939 - 17'(prod >> 14);
			OP_SQI_W: begin
				sx_q <= 50'(15'(ONE_F) - a_q) << 14;
				sr_q <= 50'd0;
				sb_q <= SQ_B0;
			end
			OP_SQI_L: begin
				sx_q <= acc_q;
				sr_q <= 50'd0;
				sb_q <= SQ_B0;
			end
			OP_SQS: begin
				if (sx_q >= sq_try) begin
					sx_q <= sx_q - sq_try;
					sr_q <= (sr_q >> 1) + sb_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				sb_q <= sb_q >> 2;
			end
			OP_ACS: ang_q <= neg_q ? 16'(PI_F - acs) : 16'(acs);
			OP_ANG2: sq_q <= prod[31:0];
			OP_TMUL: t_q <= 25'((prod[48:0] + 49'h40_0000) >> 23);
			OP_RINIT: r_q <= ONE24;
			OP_TYM: x_q <= prod[39:16];
			OP_TYR: q_q <= prod[55:32];
			OP_TYC: r_q <= ONE24 - 25'(qfix);
			OP_EXP: w_q <= (tk > 9'd16) ? 17'd0 : 17'((25'(esum[49:24]) + 25'd128) >> 8);
			OP_MAG: begin
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= sum_q[i][31] ? 32'(-sum_q[i]) : sum_q[i];
					res_q[i] <= 16'd0;
				end
			end
			OP_SHR: begin
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= mag_q[i] >> 1;
				end
			end
			OP_SHL: begin
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= mag_q[i] << 1;
				end
			end
			OP_DVI: begin
				rem_q   <= 25'(num[38:16]);
				numlo_q <= num[15:0];
				quo_q   <= 16'd0;
			end
			OP_DVS: begin
				if (rem2 >= 26'(sr_q[24:0])) begin
					rem_q <= 25'(rem2 - 26'(sr_q[24:0]));
					quo_q <= {quo_q[14:0], 1'b1};
				end else begin
					rem_q <= rem2[24:0];
					quo_q <= {quo_q[14:0], 1'b0};
				end
				numlo_q <= numlo_q << 1;
			end
			OP_DVO: res_q[cmd.idx] <= sum_q[cmd.idx][31] ? (16'd0 - qext) : qext;
			OP_OUT: begin
				out_q.filtered_x <= res_q[0];
				out_q.filtered_y <= res_q[1];
				out_q.filtered_z <= res_q[2];
			end
			default: begin
			end
		endcase
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

// ===== rtl/gns_ctrl.sv =====
`default_nettype none

module gns_ctrl import gns_pkg::*; #(
	parameter int MAX_NEIGHBORS = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      is_center,
	input  wire logic      is_self,
	input  wire logic      is_last,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire gns_stat_t stat,
	output gns_cmd_t       cmd
);

	localparam int CW = $clog2(MAX_NEIGHBORS + 1);

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_CENTER, S_DIFF, S_H, S_P1, S_P2, S_P3, S_SQI, S_SQS,
		S_ACS, S_ANG2, S_TMUL, S_RINIT, S_TYM, S_TYR, S_TYC, S_EXP, S_ADD, S_CHECK,
		S_MAG, S_NR, S_NL, S_LEN, S_SQI2, S_SQS2, S_DVI, S_DVS, S_DVO, S_OUT
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic [4:0]      step_q;
	logic [1:0]      idx_q;
	logic [3:0]      j_q;
	logic            center_q;
	logic            self_q;
	logic            last_q;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Command decode from the current state.
	always_comb begin
		cmd.idx = idx_q;
		cmd.j   = j_q;
		unique case (state_q)
			S_IDLE:    cmd.op = in_valid ? OP_LOAD : OP_NOP;
			S_CENTER:  cmd.op = OP_CENTER;
			S_DIFF:    cmd.op = OP_DIFF;
			S_H:       cmd.op = OP_H;
			S_P1:      cmd.op = OP_P1;
			S_P2:      cmd.op = OP_P2;
			S_P3:      cmd.op = OP_P3;
			S_SQI:     cmd.op = OP_SQI_W;
			S_SQS:     cmd.op = OP_SQS;
			S_ACS:     cmd.op = OP_ACS;
			S_ANG2:    cmd.op = OP_ANG2;
			S_TMUL:    cmd.op = OP_TMUL;
			S_RINIT:   cmd.op = OP_RINIT;
			S_TYM:     cmd.op = OP_TYM;
			S_TYR:     cmd.op = OP_TYR;
			S_TYC:     cmd.op = OP_TYC;
			S_EXP:     cmd.op = OP_EXP;
			S_ADD:     cmd.op = OP_ADD;
			S_MAG:     cmd.op = OP_MAG;
			S_NR:      cmd.op = stat.too_big ? OP_SHR : OP_NOP;
			S_NL:      cmd.op = stat.too_small ? OP_SHL : OP_NOP;
			S_LEN:     cmd.op = OP_LEN;
			S_SQI2:    cmd.op = OP_SQI_L;
			S_SQS2:    cmd.op = OP_SQS;
			S_DVI:     cmd.op = OP_DVI;
			S_DVS:     cmd.op = OP_DVS;
			S_DVO:     cmd.op = OP_DVO;
			S_OUT:     cmd.op = out_free ? OP_OUT : OP_NOP;
			default:   cmd.op = OP_NOP;
		endcase
	end

	// Sequencer state, loop counters and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			step_q      <= 5'd0;
			idx_q       <= 2'd0;
			j_q         <= 4'd0;
			center_q    <= 1'b0;
			self_q      <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						center_q <= is_center;
						self_q   <= is_self;
						last_q   <= is_last;
						state_q  <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					idx_q <= 2'd0;
					if (center_q) begin
						state_q <= S_CENTER;
					end else if (cnt_q < CW'(MAX_NEIGHBORS)) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= self_q ? S_CHECK : S_DIFF;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CENTER: begin
					cnt_q   <= '0;
					state_q <= S_CHECK;
				end
				S_DIFF: begin
					idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
					if (idx_q == 2'd2) begin
						state_q <= S_H;
					end
				end
				S_H:   state_q <= S_P1;
				S_P1:  state_q <= S_P2;
				S_P2:  state_q <= S_P3;
				S_P3:  state_q <= S_SQI;
				S_SQI: begin
					step_q  <= 5'd0;
					state_q <= S_SQS;
				end
				S_SQS: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'(SQ_STEPS - 1)) begin
						state_q <= S_ACS;
					end
				end
				S_ACS:  state_q <= S_ANG2;
				S_ANG2: state_q <= S_TMUL;
				S_TMUL: state_q <= S_RINIT;
				S_RINIT: begin
					j_q     <= 4'(TAYLOR_N);
					state_q <= S_TYM;
				end
				S_TYM: state_q <= S_TYR;
				S_TYR: state_q <= S_TYC;
				S_TYC: begin
					if (j_q == 4'd1) begin
						state_q <= S_EXP;
					end else begin
						j_q     <= j_q - 4'd1;
						state_q <= S_TYM;
					end
				end
				S_EXP: begin
					idx_q   <= 2'd0;
					state_q <= S_ADD;
				end
				S_ADD: begin
					idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
					if (idx_q == 2'd2) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: state_q <= last_q ? S_MAG : S_IDLE;
				S_MAG:   state_q <= stat.sum_zero ? S_OUT : S_NR;
				S_NR: begin
					if (!stat.too_big) begin
						state_q <= S_NL;
					end
				end
				S_NL: begin
					if (!stat.too_small) begin
						idx_q   <= 2'd0;
						state_q <= S_LEN;
					end
				end
				S_LEN: begin
					idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
					if (idx_q == 2'd2) begin
						state_q <= S_SQI2;
					end
				end
				S_SQI2: begin
					step_q  <= 5'd0;
					state_q <= S_SQS2;
				end
				S_SQS2: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'(SQ_STEPS - 1)) begin
						idx_q   <= 2'd0;
						state_q <= S_DVI;
					end
				end
				S_DVI: begin
					step_q  <= 5'd0;
					state_q <= S_DVS;
				end
				S_DVS: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'(DIV_STEPS - 1)) begin
						state_q <= S_DVO;
					end
				end
				S_DVO: begin
					if (idx_q == 2'd2) begin
						state_q <= S_OUT;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= S_DVI;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gaussian_normal_smoothing_unit.sv =====
// Gaussian-weighted normal smoothing: a center word opens a group, each neighbor word adds its
// normal weighted by exp(-angle^2 * inv_sigma_sq), and the word flagged last produces the
// normalized sum. One word is processed at a time. A weighted neighbor's work is set mostly by
// the 25-step shared square-root unit and the 8-term exponential series on the shared
// multiplier; a center word and a skipped or ignored neighbor bypass the weight computation.
// A result needs the normalizing shifts, the square root and three 16-step divisions, or none
// of these for a zero sum, and waits in S_OUT while the output register stays full.
// A finished result waits in the output register while the next word is already accepted.
`default_nettype none

module gaussian_normal_smoothing_unit import gns_pkg::*; #(
	parameter int MAX_NEIGHBORS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire gns_in_t     in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output gns_out_t         out_data,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata
);

	gns_cmd_t  cmd;
	gns_stat_t stat;

	// Sequencer.
	gns_ctrl #(
		.MAX_NEIGHBORS(MAX_NEIGHBORS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.is_center (in_data.is_center),
		.is_self   (in_data.is_self),
		.is_last   (in_data.is_last),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Arithmetic and group state.
	gns_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stat      (stat),
		.out_data  (out_data)
	);

`ifndef SYNTH
	// The block takes no second word in the cycle right after accepting one.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("word accepted while the previous one is being dispatched");

	// Every emitted component stays within plus or minus one.
	a_out_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.filtered_x <= 16'sd16384 && out_data.filtered_x >= -16'sd16384 &&
		out_data.filtered_y <= 16'sd16384 && out_data.filtered_y >= -16'sd16384 &&
		out_data.filtered_z <= 16'sd16384 && out_data.filtered_z >= -16'sd16384))
		else $error("filtered component out of range");
`endif

endmodule

`default_nettype wire

// ===== test/gns_checker.sv =====
`default_nettype none

module gns_checker import gns_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire gns_in_t     in_data,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire gns_out_t    out_data,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	output int               errors,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_NBR = 16;
	localparam longint unsigned ONE_Q = 64'd16384;
	localparam longint unsigned ONE_24 = 64'd16777216;
	localparam longint unsigned PI_Q14 = (64'd3373259426 + 64'd32768) >> 16;

	// Fixed-point values of exp(-k) in Q.24, k = 0..16.
	longint unsigned exp_whole [17] = '{
		64'd16777216, 64'd6171993, 64'd2270549, 64'd835288, 64'd307285, 64'd113044,
		64'd41587, 64'd15299, 64'd5628, 64'd2070, 64'd762, 64'd280, 64'd103, 64'd38,
		64'd14, 64'd5, 64'd2
	};

	// Mirror of the smoothing state.
	logic [15:0]    sigma_inv;
	longint signed  center_n [3];
	longint signed  normal_sum [3];
	int unsigned    nbr_seen;
	gns_out_t       filtered_q [$];

	assign pending = filtered_q.size();

	function automatic longint unsigned floor_sqrt(input longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Gaussian weight in Q.16 of a neighbor normal against the center normal.
	function automatic longint unsigned gauss_weight(input longint signed nx,
			input longint signed ny, input longint signed nz);
		longint signed   df [3];
		longint unsigned d, m, h, a, p, s, acs, ang, t, k, f, r, e;
		bit              neg;
		begin
			df[0] = center_n[0] - nx;
			df[1] = center_n[1] - ny;
			df[2] = center_n[2] - nz;
			d = 0;
			for (int i = 0; i < 3; i++) begin
				m = df[i] < 0 ? longint'(-df[i]) : longint'(df[i]);
				d += m * m;
			end
			h = (d + ONE_Q) >> 15;
			if (h > 2 * ONE_Q)
				h = 2 * ONE_Q;
			neg = h > ONE_Q;
			a = neg ? h - ONE_Q : ONE_Q - h;
			// Arccosine as sqrt(1 - |c|) times a cubic.
			p = 64'd4867 - ((64'd1227 * a) >> 14);
			p = 64'd13901 - ((p * a) >> 14);
			p = 64'd102939 - ((p * a) >> 14);
			s = floor_sqrt((ONE_Q - a) << 14);
			acs = (p * s + 64'd32768) >> 16;
			ang = neg ? PI_Q14 - acs : acs;
			t = (ang * ang * longint'(sigma_inv) + 64'd4194304) >> 23;
			k = t >> 16;
			if (k > 16)
				return 0;
			f = t & 64'hFFFF;
			r = ONE_24;
			for (int j = 8; j >= 1; j--)
				r = ONE_24 - ((f * r) >> 16) / longint'(j);
			e = (exp_whole[k] * r + 64'd8388608) >> 24;
			return (e + 64'd128) >> 8;
		end
	endfunction

	function automatic void accumulate(input int i, input longint unsigned w,
			input longint signed n);
		longint unsigned mag;
		longint signed   term, v;
		begin
			mag = n < 0 ? longint'(-n) : longint'(n);
			term = longint'((w * mag + 64'd32768) >> 16);
			v = normal_sum[i] + (n < 0 ? -term : term);
			if (v > 64'sd2147483647)
				v = 64'sd2147483647;
			if (v < -64'sd2147483648)
				v = -64'sd2147483648;
			normal_sum[i] = v;
		end
	endfunction

	// Normalize the running sum to a unit vector in Q1.14, or all zeros for a zero sum.
	function automatic gns_out_t normalized_sum();
		longint unsigned mag [3];
		longint unsigned m, len2, len, q;
		logic [15:0]     fld [3];
		gns_out_t        o;
		begin
			m = 0;
			for (int i = 0; i < 3; i++) begin
				mag[i] = normal_sum[i] < 0 ? longint'(-normal_sum[i]) : longint'(normal_sum[i]);
				if (mag[i] > m)
					m = mag[i];
			end
			if (m == 0)
				return '0;
			while (m >= ONE_24) begin
				m >>= 1;
				for (int i = 0; i < 3; i++)
					mag[i] >>= 1;
			end
			while (m < (ONE_24 >> 1)) begin
				m <<= 1;
				for (int i = 0; i < 3; i++)
					mag[i] <<= 1;
			end
			len2 = 0;
			for (int i = 0; i < 3; i++)
				len2 += mag[i] * mag[i];
			len = floor_sqrt(len2);
			for (int i = 0; i < 3; i++) begin
				q = (mag[i] * ONE_Q + len / 2) / len;
				if (q > ONE_Q)
					q = ONE_Q;
				fld[i] = normal_sum[i] < 0 ? 16'(-q) : 16'(q);
			end
			o.filtered_x = fld[0];
			o.filtered_y = fld[1];
			o.filtered_z = fld[2];
			return o;
		end
	endfunction

	function automatic void predict_word(input gns_in_t w);
		longint signed   n [3];
		longint unsigned wt;
		begin
			n[0] = $signed(w.normal_x);
			n[1] = $signed(w.normal_y);
			n[2] = $signed(w.normal_z);
			if (w.is_center) begin
				for (int i = 0; i < 3; i++) begin
					center_n[i] = n[i];
					normal_sum[i] = n[i];
				end
				nbr_seen = 0;
			end else if (nbr_seen < MAX_NBR) begin
				nbr_seen++;
				if (!w.is_self) begin
					wt = gauss_weight(n[0], n[1], n[2]);
					for (int i = 0; i < 3; i++)
						accumulate(i, wt, n[i]);
				end
			end
			if (w.is_last)
				filtered_q = {filtered_q, normalized_sum()};
		end
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// Watch both channels and the register port at every rising edge.
	always @(posedge clk or negedge arst_n) begin
		gns_out_t want;
		if (!arst_n) begin
			errors = 0;
			sigma_inv = INV_RESET;
			for (int i = 0; i < 3; i++) begin
				center_n[i] = 0;
				normal_sum[i] = 0;
			end
			nbr_seen = 0;
		end else begin
			if (cfg_we)
				sigma_inv = cfg_wdata;
			if (out_valid && out_ready) begin
				if (filtered_q.size() == 0) begin
					report("unexpected word, x", int'(out_data.filtered_x), 0);
				end else begin
					want = filtered_q.pop_front();
					if (out_data.filtered_x !== want.filtered_x)
						report("filtered_x", int'(out_data.filtered_x), int'(want.filtered_x));
					if (out_data.filtered_y !== want.filtered_y)
						report("filtered_y", int'(out_data.filtered_y), int'(want.filtered_y));
					if (out_data.filtered_z !== want.filtered_z)
						report("filtered_z", int'(out_data.filtered_z), int'(want.filtered_z));
				end
			end
			if (in_valid && in_ready)
				predict_word(in_data);
		end
	end

endmodule

`default_nettype wire

// ===== test/gaussian_normal_smoothing_unit_test.sv =====
`default_nettype none

module gaussian_normal_smoothing_unit_test;
	import gns_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 800000;
	localparam int RANDOM_WORDS = 450;
	localparam int SETTLE = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	gns_in_t     in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	gns_out_t    out_data;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	int          errors;
	int          pending;
	int          cycles = 0;
	int          burst_left = 0;
	int          stall_left = 0;
	int          sent = 0;
	bit          calm = 1'b0;

	always #2 clk = ~clk;

	gaussian_normal_smoothing_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	gns_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.errors(errors), .pending(pending)
	);

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// The receiver stalls in runs of random length, except in calm stretches.
	always @(negedge clk) begin
		if (!arst_n || calm) begin
			out_ready <= arst_n;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 25);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Offer one word and hold it until it is taken; gaps fall between bursts.
	task automatic send_word(input gns_in_t w);
		if (burst_left == 0) begin
			if (!calm) begin
				in_valid = 1'b0;
				repeat ($urandom_range(0, 30)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		in_data = w;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		burst_left--;
		sent++;
	endtask

	task automatic make_word(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z,
			input bit ctr, input bit self_flag, input bit last);
		gns_in_t w;
		w.normal_x = x;
		w.normal_y = y;
		w.normal_z = z;
		w.is_center = ctr;
		w.is_self = self_flag;
		w.is_last = last;
		send_word(w);
	endtask

	// Drain every expected word, then let a word that yields nothing finish.
	task automatic drain();
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_sigma(input logic [15:0] v);
		drain();
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [15:0] any_component();
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom);
		return 16'($urandom_range(0, 32768) - 16384);
	endfunction

	function automatic logic [15:0] near(input logic [15:0] c);
		if ($urandom_range(0, 5) == 0)
			return any_component();
		return c + 16'($urandom_range(0, 6000) - 3000);
	endfunction

	// One well-formed group around a random center, sometimes broken.
	task automatic random_group();
		logic [15:0] cx, cy, cz;
		int          n;
		bit          ctr_last;
		cx = any_component();
		cy = any_component();
		cz = any_component();
		n = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 20) : $urandom_range(0, 8);
		ctr_last = (n == 0) || ($urandom_range(0, 19) == 0);
		if ($urandom_range(0, 9) != 0)
			make_word(cx, cy, cz, 1'b1, $urandom_range(0, 9) == 0, ctr_last);
		for (int i = 0; i < n; i++)
			make_word(near(cx), near(cy), near(cz), 1'b0,
				$urandom_range(0, 9) == 0, (i == n - 1) || ($urandom_range(0, 24) == 0));
	endtask

	initial begin
		logic [15:0] phase_sigma [4];
		phase_sigma = '{16'd0, 16'hFFFF, 16'd13281, 16'd2048};
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Neighbor before any center, then the reset register value.
		make_word(16'sd16384, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b1);
		// Center alone with last, zero center, center with self flag.
		make_word(16'sd16384, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b1);
		make_word(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b1);
		make_word(-16'sd16384, 16'sd0, 16'sd0, 1'b1, 1'b1, 1'b0);
		// Opposite, equal and orthogonal neighbors; a skipped self word ends the group.
		make_word(16'sd16384, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0);
		make_word(-16'sd16384, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0);
		make_word(16'sd0, -16'sd16384, 16'sd0, 1'b0, 1'b0, 1'b0);
		make_word(16'sd0, 16'sd0, 16'sd16384, 1'b0, 1'b1, 1'b1);
		// State is kept after a result.
		make_word(16'sd0, 16'sd16384, 16'sd0, 1'b0, 1'b0, 1'b1);
		// Out-of-range extremes of every bit.
		make_word(16'h8000, 16'h7FFF, 16'hFFFF, 1'b1, 1'b0, 1'b0);
		make_word(16'h7FFF, 16'h8000, 16'h0001, 1'b0, 1'b0, 1'b1);
		// More neighbors than the limit; later ones are ignored but last still emits.
		make_word(16'sd11585, 16'sd11585, 16'sd0, 1'b1, 1'b0, 1'b0);
		for (int i = 0; i < 18; i++)
			make_word(16'sd11585, 16'(16'sd11000 + 16'(i * 100)), 16'sd500, 1'b0,
				i == 3, i == 17);

		// Random phases, each under a new sigma; the last one without idling.
		for (int ph = 0; ph < 5; ph++) begin
			set_sigma(ph < 4 ? phase_sigma[ph] : 16'($urandom));
			calm = (ph == 4);
			while (sent < 30 + (ph + 1) * (RANDOM_WORDS - 30) / 5)
				random_group();
		end
		calm = 1'b0;

		drain();
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire
